// ===== sv/ovli_pkg.sv =====
// shared types, status codes and fixed-point helpers for the orbit velocity interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ovli_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_STORED = 3'd1;
    localparam logic [2:0] ST_DROP   = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic [5:0] W_SHIFT = 6'd28;
    localparam logic [5:0] V_SHIFT = 6'd14;
    localparam logic [6:0] FRAC_STEPS = 7'd31;
    localparam logic [6:0] FULL_STEPS = 7'd64;

    typedef struct packed {
        op_t                op;
        logic signed [63:0] t;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } item_t;

    typedef struct packed {
        logic        start;
        logic        frac;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    // arithmetic shift right with truncation toward zero
    function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                  input logic [5:0] sh);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (v + bias) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = Q_MAX;
        else if (v < -64'sd2147483648) r = Q_MIN;
        else r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ovli_front.sv =====
// input side: decodes the mode and queues items for the back end
// depends on ovli_pkg
`timescale 1ns / 1ps
`default_nettype none

module ovli_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [159:0]   s_tdata,
    input  wire logic [1:0]     s_tuser,
    output ovli_pkg::item_t     q_item,
    output logic                q_valid,
    input  wire logic           q_ready
);
    import ovli_pkg::*;

    item_t            slot_q [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]     fill_reg, fill_next;
    item_t            in_item;
    logic             push, pop;

    always_comb begin
        // only the high mode bit picks a query
        if (s_tuser[1]) in_item.op = OP_QUERY;
        else if (s_tuser[0]) in_item.op = OP_LOAD;
        else in_item.op = OP_CLEAR;
        in_item.t  = s_tdata[63:0];
        in_item.vx = s_tdata[95:64];
        in_item.vy = s_tdata[127:96];
        in_item.vz = s_tdata[159:128];
    end

    assign s_tready = (fill_reg != (QPW+1)'(QDEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = slot_q[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) fill_next = fill_reg + 1'b1;
        else if (pop && !push) fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_q[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

// ===== sv/ovli_div.sv =====
// bit-serial unsigned divider, plain 64-bit or Q.28 fraction mode
// depends on ovli_pkg
`timescale 1ns / 1ps
`default_nettype none

module ovli_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  ovli_pkg::div_req_t      req,
    output logic                    done,
    output logic [63:0]             quo
);
    import ovli_pkg::*;

    logic [63:0] rem_reg, quo_reg, sh_reg, den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;
    logic        ge;

    assign trial = {rem_reg, sh_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.frac ? FRAC_STEPS : FULL_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.den;
            quo_reg <= '0;
            // fraction mode: quotient of num*2^28, known to be below 2^31
            if (req.frac) begin
                rem_reg <= {3'b000, req.num[63:3]};
                sh_reg  <= {req.num[2:0], 61'd0};
            end else begin
                rem_reg <= '0;
                sh_reg  <= req.num;
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
            quo_reg <= {quo_reg[62:0], ge};
            sh_reg  <= {sh_reg[62:0], 1'b0};
        end
    end

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a run");

endmodule

`default_nettype wire

// ===== sv/ovli_back.sv =====
// back end: sample table, window selection and Lagrange evaluation
// depends on ovli_pkg and ovli_div
`timescale 1ns / 1ps
`default_nettype none

module ovli_back #(
    parameter int MAX_SAMPLES = 64,
    parameter int WINDOW      = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  ovli_pkg::item_t     q_item,
    input  wire logic           q_valid,
    output logic                q_ready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [95:0]         m_tdata,
    output logic [2:0]          m_tuser
);
    import ovli_pkg::*;

    localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int HALF_M1 = WINDOW / 2 - 1;
    localparam int WM1 = WINDOW - 1;

    typedef enum logic [18:0] {
        S_IDLE = 19'h00001, S_DT  = 19'h00002, S_QD  = 19'h00004, S_WIN = 19'h00008,
        S_IRD  = 19'h00010, S_IWT = 19'h00020, S_JCK = 19'h00040, S_JWT = 19'h00080,
        S_FPR  = 19'h00100, S_FCK = 19'h00200, S_FDV = 19'h00400, S_MW  = 19'h00800,
        S_WU   = 19'h01000, S_VRD = 19'h02000, S_VWT = 19'h04000, S_VM  = 19'h08000,
        S_VA   = 19'h10000, S_FIN = 19'h20000, S_DONE = 19'h40000
    } state_t;

    state_t state_reg;

    logic signed [63:0] tmem [MAX_SAMPLES];
    logic signed [31:0] xmem [MAX_SAMPLES];
    logic signed [31:0] ymem [MAX_SAMPLES];
    logic signed [31:0] zmem [MAX_SAMPLES];
    logic signed [63:0] rd_t_reg;
    logic signed [31:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;

    logic [CW-1:0]      cnt_reg, lo_reg, hi_reg, i_reg, j_reg;
    logic signed [63:0] first_reg, last_reg, cur_t_reg, ti_reg, tj_reg;
    logic [63:0]        nm_reg, dm_reg;
    logic               neg_reg;
    logic signed [31:0] w_reg, f_reg, vx_reg, vy_reg, vz_reg, vsel;
    logic signed [63:0] prod_reg, acc_x_reg, acc_y_reg, acc_z_reg;
    logic [1:0]         k_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg;
    logic [2:0]         res_st_reg;
    logic signed [31:0] o_x_reg, o_y_reg, o_z_reg;
    logic [2:0]         o_st_reg;
    logic               o_valid_reg;

    div_req_t           dreq;
    logic               d_done;
    logic [63:0]        d_quo;

    logic [31:0]        cnt32, lo32, qc32;
    logic signed [31:0] base32;
    logic [CW-1:0]      qc;
    logic               load_ok;

    ovli_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .done    (d_done),
        .quo     (d_quo)
    );

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {o_z_reg, o_y_reg, o_x_reg};
    assign m_tuser  = o_st_reg;

    assign cnt32  = 32'(cnt_reg);
    assign lo32   = 32'(lo_reg);
    assign qc     = (d_quo > 64'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : d_quo[CW-1:0];
    assign qc32   = 32'(qc);
    assign base32 = $signed(qc32) - $signed(32'(HALF_M1));
    assign load_ok = !((cnt_reg != '0) && (q_item.t <= last_reg))
                     && (cnt32 < 32'(MAX_SAMPLES));
    assign wr_en  = (state_reg == S_IDLE) && q_valid && (q_item.op == OP_LOAD) && load_ok;

    always_comb begin
        case (state_reg)
            S_JCK:   rd_addr = j_reg[IW-1:0];
            default: rd_addr = i_reg[IW-1:0];
        endcase
    end

    always_comb begin
        case (k_reg)
            2'd0:    vsel = vx_reg;
            2'd1:    vsel = vy_reg;
            default: vsel = vz_reg;
        endcase
    end

    always_comb begin
        dreq.start = 1'b0;
        dreq.frac  = 1'b0;
        dreq.num   = 64'(last_reg - first_reg);
        dreq.den   = 64'(cnt_reg) - 64'd1;
        unique case (state_reg)
            S_IDLE: dreq.start = q_valid && (q_item.op == OP_QUERY)
                                 && (cnt_reg != '0) && (cnt32 > 32'(WINDOW));
            S_DT: begin
                dreq.start = d_done && (cur_t_reg >= first_reg);
                dreq.num   = 64'(cur_t_reg - first_reg);
                dreq.den   = d_quo;
            end
            S_FCK: begin
                dreq.start = !({3'b000, nm_reg} >= {dm_reg, 3'b000});
                dreq.frac  = 1'b1;
                dreq.num   = nm_reg;
                dreq.den   = dm_reg;
            end
            default: ;
        endcase
    end

    // table storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tmem[cnt_reg[IW-1:0]] <= q_item.t;
            xmem[cnt_reg[IW-1:0]] <= q_item.vx;
            ymem[cnt_reg[IW-1:0]] <= q_item.vy;
            zmem[cnt_reg[IW-1:0]] <= q_item.vz;
        end
        rd_t_reg <= tmem[rd_addr];
        rd_x_reg <= xmem[rd_addr];
        rd_y_reg <= ymem[rd_addr];
        rd_z_reg <= zmem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            // the result register is reloaded in S_DONE, emptied elsewhere
            if (m_tvalid && m_tready && (state_reg != S_DONE)) o_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (q_valid) begin
                    cur_t_reg <= q_item.t;
                    res_x_reg <= '0;
                    res_y_reg <= '0;
                    res_z_reg <= '0;
                    acc_x_reg <= '0;
                    acc_y_reg <= '0;
                    acc_z_reg <= '0;
                    state_reg <= S_DONE;
                    case (q_item.op)
                        OP_CLEAR: begin
                            cnt_reg    <= '0;
                            res_st_reg <= ST_STORED;
                        end
                        OP_LOAD: begin
                            if ((cnt_reg != '0) && (q_item.t <= last_reg)) begin
                                res_st_reg <= ST_DROP;
                            end else if (!load_ok) begin
                                res_st_reg <= ST_FULL;
                            end else begin
                                if (cnt_reg == '0) first_reg <= q_item.t;
                                last_reg   <= q_item.t;
                                cnt_reg    <= cnt_reg + 1'b1;
                                res_st_reg <= ST_STORED;
                            end
                        end
                        default: begin
                            if (cnt_reg == '0) begin
                                res_st_reg <= ST_EMPTY;
                            end else if (cnt32 <= 32'(WINDOW)) begin
                                lo_reg    <= '0;
                                i_reg     <= '0;
                                hi_reg    <= cnt_reg - 1'b1;
                                state_reg <= S_IRD;
                            end else begin
                                state_reg <= S_DT;
                            end
                        end
                    endcase
                end
                S_DT: if (d_done) begin
                    if (cur_t_reg >= first_reg) begin
                        state_reg <= S_QD;
                    end else begin
                        lo_reg    <= '0;
                        state_reg <= S_WIN;
                    end
                end
                S_QD: if (d_done) begin
                    lo_reg    <= base32[31] ? '0 : base32[CW-1:0];
                    state_reg <= S_WIN;
                end
                S_WIN: begin
                    // clamp the window at the end of the table
                    if (lo32 + 32'(WM1) >= cnt32 - 32'd1) begin
                        lo_reg <= CW'(cnt32 - 32'(WINDOW));
                        i_reg  <= CW'(cnt32 - 32'(WINDOW));
                        hi_reg <= cnt_reg - 1'b1;
                    end else begin
                        i_reg  <= lo_reg;
                        hi_reg <= CW'(lo32 + 32'(WM1));
                    end
                    state_reg <= S_IRD;
                end
                S_IRD: begin
                    w_reg     <= ONE_Q28;
                    j_reg     <= lo_reg;
                    state_reg <= S_IWT;
                end
                S_IWT: begin
                    ti_reg    <= rd_t_reg;
                    state_reg <= S_JCK;
                end
                S_JCK: begin
                    if (j_reg > hi_reg) state_reg <= S_VRD;
                    else if (j_reg == i_reg) j_reg <= j_reg + 1'b1;
                    else state_reg <= S_JWT;
                end
                S_JWT: begin
                    tj_reg    <= rd_t_reg;
                    state_reg <= S_FPR;
                end
                S_FPR: begin
                    nm_reg  <= (cur_t_reg < tj_reg) ? 64'(tj_reg - cur_t_reg)
                                                    : 64'(cur_t_reg - tj_reg);
                    dm_reg  <= (ti_reg < tj_reg) ? 64'(tj_reg - ti_reg)
                                                 : 64'(ti_reg - tj_reg);
                    neg_reg <= (cur_t_reg < tj_reg) != (ti_reg < tj_reg);
                    state_reg <= S_FCK;
                end
                S_FCK: begin
                    if ({3'b000, nm_reg} >= {dm_reg, 3'b000}) begin
                        f_reg     <= neg_reg ? Q_MIN : Q_MAX;
                        state_reg <= S_MW;
                    end else begin
                        state_reg <= S_FDV;
                    end
                end
                S_FDV: if (d_done) begin
                    f_reg     <= neg_reg ? -$signed(d_quo[31:0]) : $signed(d_quo[31:0]);
                    state_reg <= S_MW;
                end
                S_MW: begin
                    prod_reg  <= w_reg * f_reg;
                    state_reg <= S_WU;
                end
                S_WU: begin
                    w_reg     <= sat32(shr_tz(prod_reg, W_SHIFT));
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= S_JCK;
                end
                S_VRD: state_reg <= S_VWT;
                S_VWT: begin
                    vx_reg    <= rd_x_reg;
                    vy_reg    <= rd_y_reg;
                    vz_reg    <= rd_z_reg;
                    k_reg     <= 2'd0;
                    state_reg <= S_VM;
                end
                S_VM: begin
                    prod_reg  <= w_reg * vsel;
                    state_reg <= S_VA;
                end
                S_VA: begin
                    case (k_reg)
                        2'd0:    acc_x_reg <= acc_x_reg + shr_tz(prod_reg, V_SHIFT);
                        2'd1:    acc_y_reg <= acc_y_reg + shr_tz(prod_reg, V_SHIFT);
                        default: acc_z_reg <= acc_z_reg + shr_tz(prod_reg, V_SHIFT);
                    endcase
                    if (k_reg == 2'd2) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= (i_reg == hi_reg) ? S_FIN : S_IRD;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_VM;
                    end
                end
                S_FIN: begin
                    res_x_reg  <= sat32(shr_tz(acc_x_reg, V_SHIFT));
                    res_y_reg  <= sat32(shr_tz(acc_y_reg, V_SHIFT));
                    res_z_reg  <= sat32(shr_tz(acc_z_reg, V_SHIFT));
                    res_st_reg <= ST_OK;
                    state_reg  <= S_DONE;
                end
                S_DONE: if (!o_valid_reg || m_tready) begin
                    o_x_reg     <= res_x_reg;
                    o_y_reg     <= res_y_reg;
                    o_z_reg     <= res_z_reg;
                    o_st_reg    <= res_st_reg;
                    o_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/orbit_velocity_lagrange_interp.sv =====
// Timed velocity table with Lagrange interpolation. Mode 0 clears the table, mode 1 appends a
// sample whose time must be strictly later than the last one, mode 2 or 3 queries the velocity
// at a time. Every transaction returns one result in status and velocities. A query makes the
// spacing and index divisions when the table holds more than WINDOW samples, and the
// bit-serial divider computes each Lagrange factor that does not saturate. Input queues two
// transactions and the result register frees the back end while a result waits. Depends on
// ovli_pkg, ovli_front, ovli_back.
`timescale 1ns / 1ps
`default_nettype none

module orbit_velocity_lagrange_interp #(
    parameter int MAX_SAMPLES = 64,
    parameter int WINDOW      = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [159:0]   s_tdata,  // sample_time, in_vel_x, in_vel_y, in_vel_z
    input  wire logic [1:0]     s_tuser,  // mode
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [95:0]         m_tdata,  // out_vel_x, out_vel_y, out_vel_z
    output logic [2:0]          m_tuser   // status
);
    import ovli_pkg::*;

    item_t q_item;
    logic  q_valid, q_ready;

    ovli_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    ovli_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .WINDOW      (WINDOW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
